/* hw/rtl/gf16_poly_counter_prg_unit_macros.svh */
// Assertion macros for the GF(2^16) polynomial counter PRG
`ifndef GF16_POLY_COUNTER_PRG_UNIT_MACROS_SVH
`define GF16_POLY_COUNTER_PRG_UNIT_MACROS_SVH

// same-cycle implication
`define GPCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gf16pcp: same-cycle check failed");

// next-cycle implication
`define GPCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gf16pcp: next-cycle check failed");

`endif

/* hw/rtl/gf16pcp_pkg.sv */
// Package: types, constants, microcode ROM and GF arithmetic for the PRG
package gf16pcp_pkg;

  localparam int DefaultDegree = 3;
  localparam int NumCoef       = 4;
  localparam int CoefIdxW      = 2;
  localparam int CoefW         = 16;
  localparam int ByteW         = 8;
  localparam int CfgIdxW       = 4;
  localparam int StepW         = 3;

  localparam logic [ByteW-1:0] GfT5     = 8'd32;
  localparam logic [ByteW-1:0] ByteMask = 8'd255;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepFetch  = 3'd0;
  localparam step_t StepLoad   = 3'd1;
  localparam step_t StepMac    = 3'd2;
  localparam step_t StepEmitLo = 3'd3;
  localparam step_t StepEmitHi = 3'd4;

  typedef enum logic [1:0] {
    CondNext = 2'd0,
    CondPend = 2'd1,
    CondLoop = 2'd2,
    CondJump = 2'd3
  } cond_e;

  typedef struct packed {
    logic  accept;
    logic  load;
    logic  mac;
    logic  emit_lo;
    logic  emit_hi;
    cond_e cond;
    step_t target;
  } cw_t;

  // strobes issued by the sequencer, all but in_ready already gated by stalls
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic load;
    logic mac;
    logic emit_lo;
    logic emit_hi;
  } ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic pend;
    logic idx_zero;
  } stat_t;

  function automatic cw_t ucode_rom(step_t s);
    cw_t w;
    w = '{accept: 1'b0, load: 1'b0, mac: 1'b0, emit_lo: 1'b0, emit_hi: 1'b0,
          cond: CondJump, target: StepFetch};
    unique case (s)
      StepFetch: begin
        w.accept = 1'b1;
        w.cond   = CondPend;
        w.target = StepEmitHi;
      end
      StepLoad: begin
        w.load = 1'b1;
        w.cond = CondNext;
      end
      StepMac: begin
        w.mac    = 1'b1;
        w.cond   = CondLoop;
        w.target = StepMac;
      end
      StepEmitLo: begin
        w.emit_lo = 1'b1;
      end
      StepEmitHi: begin
        w.emit_hi = 1'b1;
      end
      default: begin
        w.cond = CondJump;
      end
    endcase
    return w;
  endfunction

  // AES field multiply, reduction by 0x11B
  function automatic logic [ByteW-1:0] gf8_mul(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < ByteW; k++) begin
      if (b[k]) acc = acc ^ x;
      x = x[ByteW-1] ? ((x << 1) ^ 8'h1B) : (x << 1);
    end
    return acc;
  endfunction

endpackage

/* hw/rtl/gf16_poly_counter_prg_unit.sv */
// Even request: accept to output valid through fetch, load, DEGREE MACs and emit.
// Odd request: fetch, then emit of the held high byte.
// Throughput is set by the single shared GF(2^16) multiply-add walked by the microcode loop;
// a new request is accepted only once the previous byte has been emitted.
// Reset (async, active low) clears coefficients, counter, phase and output valid.
module gf16_poly_counter_prg_unit
  import gf16pcp_pkg::*;
#(
  parameter int DEGREE = DefaultDegree
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   random_byte_o
);

  `include "gf16_poly_counter_prg_unit_macros.svh"

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ctl.in_ready;

  gf16pcp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  gf16pcp_dpath #(
    .DEGREE (DEGREE)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .restart_i     (restart_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .random_byte_o (random_byte_o),
    .stat_o        (stat)
  );

  `GPCP_ASSERT_NEXT(a_emit_valid, ctl.emit_lo || ctl.emit_hi, out_valid_o)
  `GPCP_ASSERT_NOW(a_one_op, 1'b1,
                   $onehot0({ctl.accept, ctl.load, ctl.mac, ctl.emit_lo, ctl.emit_hi}))
  `GPCP_ASSERT_NEXT(a_loop_exit, ctl.mac && stat.idx_zero, !ctl.mac)

endmodule

/* hw/rtl/gf16pcp_mul.sv */
// GF(2^16) multiply-add over GF(2^8)[x]/(x^2 + x + t^5)
module gf16pcp_mul
  import gf16pcp_pkg::*;
(
  input  logic [CoefW-1:0] a_i,
  input  logic [CoefW-1:0] b_i,
  input  logic [CoefW-1:0] c_i,
  output logic [CoefW-1:0] y_o
);

  logic [ByteW-1:0] hh;
  logic [ByteW-1:0] lo;
  logic [ByteW-1:0] hi;

  always_comb begin
    hh = gf8_mul(a_i[15:8], b_i[15:8]);
    lo = gf8_mul(a_i[7:0], b_i[7:0]) ^ gf8_mul(GfT5, hh);
    hi = gf8_mul(a_i[15:8], b_i[7:0]) ^ gf8_mul(a_i[7:0], b_i[15:8]) ^ hh;
  end

  assign y_o = {hi, lo} ^ c_i;

endmodule

/* hw/rtl/gf16pcp_seq.sv */
// Microcode sequencer: step counter, control ROM and branch logic
module gf16pcp_seq
  import gf16pcp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  step_t step_q, step_d;
  cw_t   cw;
  logic  stall;

  assign cw    = ucode_rom(step_q);
  assign stall = (cw.accept & ~stat_i.in_valid) |
                 ((cw.emit_lo | cw.emit_hi) & stat_i.out_busy);

  always_comb begin
    ctl_o.in_ready = cw.accept;
    ctl_o.accept   = cw.accept  & ~stall;
    ctl_o.load     = cw.load    & ~stall;
    ctl_o.mac      = cw.mac     & ~stall;
    ctl_o.emit_lo  = cw.emit_lo & ~stall;
    ctl_o.emit_hi  = cw.emit_hi & ~stall;
  end

  always_comb begin
    step_d = step_q;
    if (!stall) begin
      unique case (cw.cond)
        CondNext: step_d = step_q + 1'b1;
        CondPend: step_d = stat_i.pend ? cw.target : step_q + 1'b1;
        CondLoop: step_d = stat_i.idx_zero ? step_q + 1'b1 : cw.target;
        CondJump: step_d = cw.target;
        default:  step_d = StepFetch;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepFetch;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* hw/rtl/gf16pcp_dpath.sv */
// Datapath: coefficients, counter, Horner accumulator and output register
module gf16pcp_dpath
  import gf16pcp_pkg::*;
#(
  parameter int DEGREE = DefaultDegree
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoefW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               restart_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ByteW-1:0]   random_byte_o,
  output stat_t              stat_o
);

  localparam int IdxW = (DEGREE > 1) ? $clog2(DEGREE + 1) : 1;

  logic [CoefW-1:0] coef_q [NumCoef];
  logic [CoefW-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [ByteW-1:0] held_q, held_d;
  logic [CoefW-1:0] acc_q, acc_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;

  logic [IdxW-1:0]  idx_sel;
  logic [31:0]      sel_w;
  logic [CoefW-1:0] coef_cur;
  logic [CoefW-1:0] mac_y;

  assign idx_sel = ctl_i.load ? IdxW'(DEGREE) : idx_q;
  assign sel_w   = 32'(idx_sel);

  always_comb begin
    coef_cur = '0;
    if (sel_w < NumCoef) coef_cur = coef_q[sel_w[CoefIdxW-1:0]];
  end

  gf16pcp_mul u_mul (
    .a_i (acc_q),
    .b_i (cnt_q),
    .c_i (coef_cur),
    .y_o (mac_y)
  );

  always_comb begin
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    held_d      = held_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_byte_d  = out_byte_q;
    if (ctl_i.accept && restart_i) begin
      cnt_d  = '0;
      pend_d = 1'b0;
    end
    if (ctl_i.load) begin
      acc_d = coef_cur;
      idx_d = IdxW'(DEGREE - 1);
    end
    if (ctl_i.mac) begin
      acc_d = mac_y;
      idx_d = idx_q - 1'b1;
    end
    if (ctl_i.emit_lo) begin
      out_byte_d  = acc_q[7:0] & ByteMask;
      held_d      = acc_q[15:8];
      pend_d      = 1'b1;
      cnt_d       = cnt_q + 1'b1;
      out_valid_d = 1'b1;
    end
    if (ctl_i.emit_hi) begin
      out_byte_d  = held_q;
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) coef_q[i] <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (32'(cfg_index_i) < NumCoef)) begin
        coef_q[cfg_index_i[CoefIdxW-1:0]] <= cfg_data_i;
      end
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    idx_q      <= idx_d;
    out_byte_q <= out_byte_d;
  end

  always_comb begin
    stat_o.in_valid = in_valid_i;
    stat_o.out_busy = out_valid_q & ~out_ready_i;
    stat_o.pend     = pend_q & ~restart_i;
    stat_o.idx_zero = (idx_q == '0);
  end

  assign out_valid_o   = out_valid_q;
  assign random_byte_o = out_byte_q;

endmodule
